>>> rtl/core/sbc_pkg.sv
// Shared types, constants and helpers for the sprite blitter.
package sbc_pkg;

	// Default screen geometry.
	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 768;

	// Field widths.
	localparam int PIX_W   = 16;
	localparam int ADDR_W  = 20;
	localparam int POS_W   = 13;
	localparam int DIM_W   = 11;
	localparam int CNT_W   = 10;
	localparam int COORD_W = 14;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;

	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_POS_X      = 3'd0;
	localparam logic [IDX_W-1:0] REG_POS_Y      = 3'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH      = 3'd2;
	localparam logic [IDX_W-1:0] REG_HEIGHT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_ALIGN      = 3'd4;
	localparam logic [IDX_W-1:0] REG_KEY_COLOUR = 3'd5;
	localparam logic [IDX_W-1:0] REG_KEY_ENABLE = 3'd6;

	// Alignment codes.
	localparam logic [1:0] ALIGN_LEFT = 2'd0;
	localparam logic [1:0] ALIGN_MID  = 2'd1;
	localparam logic [1:0] ALIGN_END  = 2'd2;

	// Effective configuration seen by the datapath.
	typedef struct packed {
		logic signed [COORD_W-1:0] x_aligned;
		logic signed [POS_W-1:0]   pos_y;
		logic [DIM_W-1:0]          width;
		logic [DIM_W-1:0]          height;
		logic [PIX_W-1:0]          key_colour;
		logic                      key_enable;
	} cfg_t;

	// Per-pixel screen position and end-of-sprite flag.
	typedef struct packed {
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] line;
		logic                      done;
	} pos_t;

	// Zero reads as one, anything above the maximum saturates.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = 11'd1;
		end else if (d > MAX_DIM) begin
			r = MAX_DIM;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/sbc_cfg_regs.sv
// Configuration registers and derived sprite geometry.
module sbc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr,
	input  logic [sbc_pkg::IDX_W-1:0]   index,
	input  logic [sbc_pkg::DATA_W-1:0]  data,
	output sbc_pkg::cfg_t               cfg
);

	logic [sbc_pkg::POS_W-1:0] pos_x_q;
	logic [sbc_pkg::POS_W-1:0] pos_y_q;
	logic [sbc_pkg::DIM_W-1:0] width_q;
	logic [sbc_pkg::DIM_W-1:0] height_q;
	logic [1:0]                align_q;
	logic [sbc_pkg::PIX_W-1:0] key_colour_q;
	logic                      key_enable_q;

	logic [sbc_pkg::DIM_W-1:0]          w_eff;
	logic [sbc_pkg::DIM_W-1:0]          h_eff;
	logic signed [sbc_pkg::COORD_W-1:0] x_ext;
	logic signed [sbc_pkg::COORD_W-1:0] x_sub;

	// Register writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			width_q      <= 11'd1;
			height_q     <= 11'd1;
			align_q      <= sbc_pkg::ALIGN_LEFT;
			key_colour_q <= '0;
			key_enable_q <= 1'b1;
		end else if (wr) begin
			unique case (index)
				sbc_pkg::REG_POS_X:      pos_x_q      <= data[sbc_pkg::POS_W-1:0];
				sbc_pkg::REG_POS_Y:      pos_y_q      <= data[sbc_pkg::POS_W-1:0];
				sbc_pkg::REG_WIDTH:      width_q      <= data[sbc_pkg::DIM_W-1:0];
				sbc_pkg::REG_HEIGHT:     height_q     <= data[sbc_pkg::DIM_W-1:0];
				sbc_pkg::REG_ALIGN:      align_q      <= data[1:0];
				sbc_pkg::REG_KEY_COLOUR: key_colour_q <= data[sbc_pkg::PIX_W-1:0];
				sbc_pkg::REG_KEY_ENABLE: key_enable_q <= data[0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions and apply the horizontal alignment.
	always_comb begin
		w_eff = sbc_pkg::eff_dim(width_q);
		h_eff = sbc_pkg::eff_dim(height_q);
		x_ext = $signed({pos_x_q[sbc_pkg::POS_W-1], pos_x_q});
		unique case (align_q)
			sbc_pkg::ALIGN_MID: x_sub = $signed({4'b0, w_eff[sbc_pkg::DIM_W-1:1]});
			sbc_pkg::ALIGN_END: x_sub = $signed({3'b0, w_eff});
			default:            x_sub = '0;
		endcase
		cfg.x_aligned  = x_ext - x_sub;
		cfg.pos_y      = $signed(pos_y_q);
		cfg.width      = w_eff;
		cfg.height     = h_eff;
		cfg.key_colour = key_colour_q;
		cfg.key_enable = key_enable_q;
	end

endmodule

>>> rtl/core/sbc_sequencer.sv
// Column and row counters and the screen position of the next pixel.
module sbc_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sbc_pkg::cfg_t cfg,
	output sbc_pkg::pos_t pos
);

	logic [sbc_pkg::CNT_W-1:0] column_q;
	logic [sbc_pkg::CNT_W-1:0] row_q;
	logic [sbc_pkg::DIM_W-1:0] column_inc;
	logic [sbc_pkg::DIM_W-1:0] row_inc;
	logic                      last_col;

	// Rows are placed bottom-up relative to the sprite top.
	always_comb begin
		column_inc = {1'b0, column_q} + 11'd1;
		row_inc    = {1'b0, row_q} + 11'd1;
		last_col   = column_inc >= cfg.width;
		pos.done   = last_col && (row_inc >= cfg.height);
		pos.col    = cfg.x_aligned + $signed({4'b0, column_q});
		pos.line   = $signed({cfg.pos_y[sbc_pkg::POS_W-1], cfg.pos_y})
		             + $signed({3'b0, cfg.height}) - 14'sd1
		             - $signed({4'b0, row_q});
	end

	// Advance the counters on each accepted pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (step) begin
			if (last_col) begin
				column_q <= '0;
				row_q    <= pos.done ? '0 : row_inc[sbc_pkg::CNT_W-1:0];
			end else begin
				column_q <= column_inc[sbc_pkg::CNT_W-1:0];
			end
		end
	end

endmodule

>>> rtl/core/sbc_addr_gen.sv
// Clipping, color key test and framebuffer address for one pixel.
module sbc_addr_gen #(
	parameter int SCREEN_WIDTH  = sbc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = sbc_pkg::SCREEN_HEIGHT_DEF
) (
	input  sbc_pkg::pos_t              pos,
	input  logic [sbc_pkg::PIX_W-1:0]  pixel,
	input  logic [sbc_pkg::PIX_W-1:0]  key_colour,
	input  logic                       key_enable,
	output logic                       write_enable,
	output logic [sbc_pkg::ADDR_W-1:0] fb_address
);

	localparam int COL_W  = $clog2(SCREEN_WIDTH);
	localparam int LINE_W = $clog2(SCREEN_HEIGHT);
	localparam int PROD_W = LINE_W + COL_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int CMP_W  = sbc_pkg::COORD_W - 1;
	localparam logic [CMP_W-1:0] SW_C = CMP_W'(SCREEN_WIDTH);
	localparam logic [CMP_W-1:0] SH_C = CMP_W'(SCREEN_HEIGHT);
	localparam logic [COL_W:0]   SW_M = (COL_W + 1)'(SCREEN_WIDTH);

	logic                                visible;
	logic                                keyed;
	logic [PROD_W-1:0]                   prod;
	logic [SUM_W-1:0]                    sum;
	logic [SUM_W+sbc_pkg::ADDR_W-1:0]    sum_wide;

	// Line times screen width plus column, low address bits kept.
	always_comb begin
		visible = !pos.col[sbc_pkg::COORD_W-1] && (pos.col[CMP_W-1:0] < SW_C)
		          && !pos.line[sbc_pkg::COORD_W-1] && (pos.line[CMP_W-1:0] < SH_C);
		keyed   = key_enable && (pixel == key_colour);
		prod    = PROD_W'(pos.line[LINE_W-1:0] * SW_M);
		sum     = {1'b0, prod} + SUM_W'(pos.col[COL_W-1:0]);
		sum_wide = {{sbc_pkg::ADDR_W{1'b0}}, sum};
		write_enable = visible && !keyed;
		fb_address   = write_enable ? sum_wide[sbc_pkg::ADDR_W-1:0] : '0;
	end

endmodule

>>> rtl/core/sprite_blit_clip_color_key.sv
// Top level of the sprite blitter with clipping and color key.
//
// Sprite pixels enter on the input channel (pixel_in, in_valid, in_stall) in
// stored row order and leave on the output channel (write_enable, fb_address,
// pixel_out, sprite_done, out_valid, out_stall), one result per pixel.
// A transfer takes place at a clock edge with valid high and stall low.
// Geometry and color key are set through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high, and
// writes belong between sprites while no pixel is in flight.
// The datapath is two registers deep: the input register holds the pixel with
// its screen position, the result register holds the address and enables.
// A result is offered once its pixel has moved on from the input register to
// the result register. While the receiver does not stall, one pixel per cycle
// is sustained, as each register passes on its pixel when it takes the next.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises only when both hold data.
// Reset clears the counters and both valid flags and loads the register
// defaults; the next pixel is then taken as column 0 of sprite row 0.
module sprite_blit_clip_color_key #(
	parameter int SCREEN_WIDTH  = sbc_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = sbc_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sbc_pkg::PIX_W-1:0]   pixel_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        write_enable,
	output logic [sbc_pkg::ADDR_W-1:0]  fb_address,
	output logic [sbc_pkg::PIX_W-1:0]   pixel_out,
	output logic                        sprite_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sbc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [sbc_pkg::DATA_W-1:0]  cfg_data
);

	sbc_pkg::cfg_t cfg;
	sbc_pkg::pos_t pos_next;
	sbc_pkg::pos_t pos_s1;

	logic                        valid_s1;
	logic [sbc_pkg::PIX_W-1:0]   pixel_s1;
	logic                        valid_s2;
	logic                        we_s2;
	logic [sbc_pkg::ADDR_W-1:0]  addr_s2;
	logic [sbc_pkg::PIX_W-1:0]   pixel_s2;
	logic                        done_s2;

	logic                        out_free;
	logic                        advance;
	logic                        accept;
	logic                        we_calc;
	logic [sbc_pkg::ADDR_W-1:0]  addr_calc;

	assign cfg_ready = 1'b1;

	sbc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	sbc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cfg    (cfg),
		.pos    (pos_next)
	);

	sbc_addr_gen #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_addr (
		.pos          (pos_s1),
		.pixel        (pixel_s1),
		.key_colour   (cfg.key_colour),
		.key_enable   (cfg.key_enable),
		.write_enable (we_calc),
		.fb_address   (addr_calc)
	);

	// Pipeline flow control.
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register: pixel with its screen position.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel_in;
			pos_s1   <= pos_next;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			we_s2    <= we_calc;
			addr_s2  <= addr_calc;
			pixel_s2 <= pixel_s1;
			done_s2  <= pos_s1.done;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign fb_address   = addr_s2;
	assign pixel_out    = pixel_s2;
	assign sprite_done  = done_s2;

endmodule

>>> tb/sprite_blit_clip_color_key_tb.sv
// Self-checking testbench for the sprite blitter with clipping and color key.
module sprite_blit_clip_color_key_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_W     = sbc_pkg::PIX_W;
	localparam int ADDR_W    = sbc_pkg::ADDR_W;
	localparam int POS_W     = sbc_pkg::POS_W;
	localparam int DIM_W     = sbc_pkg::DIM_W;
	localparam int CNT_W     = sbc_pkg::CNT_W;
	localparam int IDX_W     = sbc_pkg::IDX_W;
	localparam int DATA_W    = sbc_pkg::DATA_W;
	localparam int SCR_W     = sbc_pkg::SCREEN_WIDTH_DEF;
	localparam int SCR_H     = sbc_pkg::SCREEN_HEIGHT_DEF;
	localparam int LONG_HOLD = 64;
	localparam int RAND_ITEMS = 550;
	localparam int CALM_TAIL  = 90;

	// One framebuffer write as the block should present it.
	typedef struct {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pix;
		logic              done;
	} fb_write_t;

	// Tracks sprite geometry and the column/row counters, and works out where each
	// pixel lands on screen; holds those writes until the block delivers them.
	class sprite_placer;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [DIM_W-1:0]        width_reg;
		logic [DIM_W-1:0]        height_reg;
		logic [1:0]              align_reg;
		logic [PIX_W-1:0]        key_colour;
		logic                    key_enable;
		logic [CNT_W-1:0]        col_cnt;
		logic [CNT_W-1:0]        row_cnt;
		fb_write_t               pending_writes[$];
		int                      errors;

		function new();
			pos_x      = '0;
			pos_y      = '0;
			width_reg  = 11'd1;
			height_reg = 11'd1;
			align_reg  = sbc_pkg::ALIGN_LEFT;
			key_colour = '0;
			key_enable = 1'b1;
			col_cnt    = '0;
			row_cnt    = '0;
			errors     = 0;
		endfunction

		// Zero counts as one pixel, oversized dimensions clamp to 1024.
		function int span_of(logic [DIM_W-1:0] d);
			if (d == 0) begin
				return 1;
			end
			return (d > 1024) ? 1024 : int'(d);
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				sbc_pkg::REG_POS_X: begin
					pos_x = data[POS_W-1:0];
				end
				sbc_pkg::REG_POS_Y: begin
					pos_y = data[POS_W-1:0];
				end
				sbc_pkg::REG_WIDTH: begin
					width_reg = data[DIM_W-1:0];
				end
				sbc_pkg::REG_HEIGHT: begin
					height_reg = data[DIM_W-1:0];
				end
				sbc_pkg::REG_ALIGN: begin
					align_reg = data[1:0];
				end
				sbc_pkg::REG_KEY_COLOUR: begin
					key_colour = data[PIX_W-1:0];
				end
				sbc_pkg::REG_KEY_ENABLE: begin
					key_enable = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Place one accepted pixel and advance the counters.
		function void take_pixel(logic [PIX_W-1:0] pix);
			int w, h, x, y, col, line;
			bit visible, keyed, last_col;
			fb_write_t wr;
			w = span_of(width_reg);
			h = span_of(height_reg);
			x = pos_x;
			y = pos_y;
			if (align_reg == sbc_pkg::ALIGN_MID) begin
				x = x - w / 2;
			end else if (align_reg == sbc_pkg::ALIGN_END) begin
				x = x - w;
			end
			col  = x + int'(col_cnt);
			line = y + h - 1 - int'(row_cnt);
			visible = col >= 0 && col < SCR_W && line >= 0 && line < SCR_H;
			keyed   = key_enable && pix == key_colour;
			wr.we   = visible && !keyed;
			wr.addr = wr.we ? ADDR_W'(line * SCR_W + col) : '0;
			wr.pix  = pix;
			last_col = int'(col_cnt) + 1 >= w;
			wr.done  = last_col && int'(row_cnt) + 1 >= h;
			if (last_col) begin
				col_cnt = '0;
				row_cnt = wr.done ? '0 : row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
			pending_writes.push_back(wr);
		endfunction

		// Pixels still needed to finish the current sprite, capped at 4096.
		function int sprite_left();
			int w, h, c, r, n;
			bit last;
			w = span_of(width_reg);
			h = span_of(height_reg);
			c = col_cnt;
			r = row_cnt;
			n = 0;
			while (n < 4096) begin
				n++;
				last = c + 1 >= w;
				if (last && r + 1 >= h) begin
					return n;
				end
				if (last) begin
					c = 0;
					r = (r + 1) % 1024;
				end else begin
					c = (c + 1) % 1024;
				end
			end
			return n;
		endfunction

		function int outstanding();
			return pending_writes.size();
		endfunction

		// Compare a delivered write against the oldest outstanding one.
		function void check_write(logic we, logic [ADDR_W-1:0] addr,
				logic [PIX_W-1:0] pix, logic done);
			fb_write_t wr;
			if (pending_writes.size() == 0) begin
				$error("result with nothing outstanding: we=%0b addr=%0d pix=%h done=%0b",
					we, addr, pix, done);
				errors++;
				return;
			end
			wr = pending_writes.pop_front();
			if (we !== wr.we) begin
				$error("write_enable: expected %0b, got %0b", wr.we, we);
				errors++;
			end
			if (addr !== wr.addr) begin
				$error("fb_address: expected %0d, got %0d", wr.addr, addr);
				errors++;
			end
			if (pix !== wr.pix) begin
				$error("pixel_out: expected %h, got %h", wr.pix, pix);
				errors++;
			end
			if (done !== wr.done) begin
				$error("sprite_done: expected %0b, got %0b", wr.done, done);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [PIX_W-1:0]    pixel_in;
	logic                out_valid;
	logic                out_stall;
	logic                write_enable;
	logic [ADDR_W-1:0]   fb_address;
	logic [PIX_W-1:0]    pixel_out;
	logic                sprite_done;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;

	sprite_placer placer;
	bit tx_idle_on;
	bit rx_idle_on;
	bit hold_req;

	sprite_blit_clip_color_key #(
		.SCREEN_WIDTH (SCR_W),
		.SCREEN_HEIGHT(SCR_H)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_enable(write_enable),
		.fb_address  (fb_address),
		.pixel_out   (pixel_out),
		.sprite_done (sprite_done),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#3_000_000;
		$display("** sprite_blit_clip_color_key: FAILED **");
		$finish;
	end

	// Receiver stall pattern: random bursts, plus one long hold on request.
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Check every result transfer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			placer.check_write(write_enable, fb_address, pixel_out, sprite_done);
		end
	end

	// Offer one pixel, with an optional gap first, and wait for its transfer.
	task automatic push_pixel(input logic [PIX_W-1:0] pix);
		int gap;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do begin
			@(posedge clk);
		end while (in_stall);
		placer.take_pixel(pix);
	endtask

	// Stop sending and wait until every outstanding write has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (placer.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		placer.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram the whole sprite setup once the block has gone quiet.
	task automatic set_sprite(input logic [15:0] xd, input logic [15:0] yd,
			input logic [15:0] wd, input logic [15:0] hd, input logic [1:0] al,
			input logic [15:0] key, input logic ken);
		drain();
		write_reg(sbc_pkg::REG_POS_X, xd);
		write_reg(sbc_pkg::REG_POS_Y, yd);
		write_reg(sbc_pkg::REG_WIDTH, wd);
		write_reg(sbc_pkg::REG_HEIGHT, hd);
		write_reg(sbc_pkg::REG_ALIGN, 16'(al));
		write_reg(sbc_pkg::REG_KEY_COLOUR, key);
		write_reg(sbc_pkg::REG_KEY_ENABLE, 16'(ken));
	endtask

	// Coordinates cluster around the screen edges so clipping is hit often.
	function automatic logic [POS_W-1:0] pick_coord(input int span);
		int v;
		case ($urandom_range(0, 3))
			0: begin
				v = int'($urandom_range(0, 24)) - 14;
			end
			1: begin
				v = span - 14 + int'($urandom_range(0, 24));
			end
			2: begin
				v = int'($urandom_range(0, span - 1));
			end
			default: begin
				v = int'($urandom_range(0, 8191)) - 4096;
			end
		endcase
		return v[POS_W-1:0];
	endfunction

	initial begin : stimulus
		int phase, rand_items, n, kind, w, h;
		logic [15:0] xd, yd, wd, hd, key, pix;
		logic [1:0] al;
		logic ken;

		placer     = new();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		pixel_in   = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: a black pixel is keyed out, a white one lands at 0.
		push_pixel(16'h0000);
		push_pixel(16'hFFFF);

		// Sprite wholly off screen at the most negative x and the largest y.
		set_sprite(16'hF000, 16'h0FFF, 16'd2, 16'd1, sbc_pkg::ALIGN_LEFT, 16'hFFFF, 1'b1);
		push_pixel(16'h8001);
		push_pixel(16'h7FFE);

		// Zero sizes act as one, align code three acts as left, bottom-right corner.
		set_sprite(16'd1023, 16'd767, 16'hF800, 16'h0000, 2'd3, 16'h0000, 1'b0);
		push_pixel(16'h0000);

		// Oversized width clamps to 1024 with center alignment; sprite left unfinished.
		set_sprite(16'd514, 16'd0, 16'h07FF, 16'd2, sbc_pkg::ALIGN_MID, 16'h5555, 1'b1);
		push_pixel(16'h5555);
		push_pixel(16'h0F0F);
		push_pixel(16'hF0F0);

		// Shrink mid-sprite so the column counter wraps; right alignment clips left.
		set_sprite(16'd2, 16'h1FFF, 16'd3, 16'd3, sbc_pkg::ALIGN_END, 16'h1234, 1'b0);
		for (int i = 0; i < 10; i++) begin
			push_pixel((i % 3 == 0) ? 16'h1234 : 16'($urandom));
		end

		// Key colour and a near miss, clipped on the right and below the screen.
		set_sprite(16'd1020, 16'd766, 16'd6, 16'd3, sbc_pkg::ALIGN_LEFT, 16'hA5A5, 1'b1);
		push_pixel(16'hA5A5);
		push_pixel(16'hA5A4);
		push_pixel(16'h5A5A);
		push_pixel(16'hA5A5);

		// Random sprites, mostly complete ones, some cut short or oversized.
		phase      = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			kind = $urandom_range(0, 9);
			xd = 16'($urandom);
			yd = 16'($urandom);
			wd = 16'($urandom);
			hd = 16'($urandom);
			xd[POS_W-1:0] = pick_coord(SCR_W);
			yd[POS_W-1:0] = pick_coord(SCR_H);
			if (kind != 0 || phase == 6) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 6);
				if (phase == 6) begin
					w = 24;
					h = 2;
				end
				wd[DIM_W-1:0] = DIM_W'(w);
				hd[DIM_W-1:0] = DIM_W'(h);
			end
			al  = 2'($urandom_range(0, 3));
			key = 16'($urandom);
			ken = $urandom_range(0, 3) != 0;
			set_sprite(xd, yd, wd, hd, al, key, ken);

			if (rand_items >= RAND_ITEMS - CALM_TAIL) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else begin
				tx_idle_on = $urandom_range(0, 3) != 0;
				rx_idle_on = $urandom_range(0, 3) != 0;
			end

			n = placer.sprite_left();
			if (phase == 6) begin
				// Hold the output while pixels keep coming so the input backs up.
				hold_req   = 1'b1;
				tx_idle_on = 1'b0;
			end else if (kind == 0 || n > 80) begin
				n = $urandom_range(1, 20);
			end else if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, n);
			end

			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 7))
					0, 1: begin
						pix = key;
					end
					2: begin
						pix = key ^ (16'd1 << $urandom_range(0, 15));
					end
					default: begin
						pix = 16'($urandom);
					end
				endcase
				push_pixel(pix);
			end
			rand_items += n;
			phase++;
		end

		// Let the pipeline empty, then report.
		drain();
		repeat (8) @(posedge clk);
		if (placer.outstanding() != 0) begin
			$error("%0d expected writes never arrived", placer.outstanding());
			placer.errors++;
		end
		if (placer.errors == 0) begin
			$display("** sprite_blit_clip_color_key: PASSED **");
		end else begin
			$display("** sprite_blit_clip_color_key: FAILED **");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_cfg_regs.sv
rtl/core/sbc_sequencer.sv
rtl/core/sbc_addr_gen.sv
rtl/core/sprite_blit_clip_color_key.sv
tb/sprite_blit_clip_color_key_tb.sv
